// ===== rtl/tpsc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the two-point sensor calibration block: widths, register indexes and item types.
package tpsc_pkg;

  localparam int RAW_W     = 16;
  localparam int TEMP_PT_W = 10;
  localparam int HUM_PT_W  = 8;
  localparam int Y_W       = 13;
  localparam int DIF_W     = RAW_W + 1;
  localparam int DY_W      = Y_W + 1;
  localparam int PROD_W    = DIF_W + DY_W;
  localparam int DEN_W     = RAW_W;
  localparam int QMAG_W    = 32;
  localparam int DIV_STEP  = 4;
  localparam int DIV_STAGES = QMAG_W / DIV_STEP;
  localparam int Q_W       = QMAG_W + 1;
  localparam int SUM_W     = Q_W + 1;
  localparam int LANE_LAT  = DIV_STAGES + 5;

  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 5;
  localparam int IDX_W     = 3;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'((1 <<< (RAW_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(1 <<< (RAW_W - 1));

  localparam logic [IDX_W-1:0] REG_TEMP_LOW_EIGHTHS  = 3'd0;
  localparam logic [IDX_W-1:0] REG_TEMP_HIGH_EIGHTHS = 3'd1;
  localparam logic [IDX_W-1:0] REG_TEMP_LOW_RAW      = 3'd2;
  localparam logic [IDX_W-1:0] REG_TEMP_HIGH_RAW     = 3'd3;
  localparam logic [IDX_W-1:0] REG_HUM_LOW_HALVES    = 3'd4;
  localparam logic [IDX_W-1:0] REG_HUM_HIGH_HALVES   = 3'd5;
  localparam logic [IDX_W-1:0] REG_HUM_LOW_RAW       = 3'd6;
  localparam logic [IDX_W-1:0] REG_HUM_HIGH_RAW      = 3'd7;

  typedef struct packed {
    logic signed [RAW_W-1:0] humidity_raw;
    logic signed [RAW_W-1:0] temperature_raw;
  } in_item_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] temperature_q;
    logic signed [RAW_W-1:0] humidity_q;
    logic                    temp_cal_error;
    logic                    hum_cal_error;
  } out_item_t;

  typedef struct packed {
    logic [DIF_W-1:0] dr;
    logic [DY_W-1:0]  dy;
    logic [DIF_W-1:0] den;
    logic [Y_W-1:0]   y0;
    logic             err;
  } lane_s1_t;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [DEN_W-1:0]  den_mag;
    logic              den_neg;
    logic [Y_W-1:0]    y0;
    logic              err;
  } lane_s2_t;

  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [QMAG_W-1:0] acc;
    logic [DEN_W-1:0]  den;
    logic              neg;
    logic [Y_W-1:0]    y0;
    logic              err;
  } lane_div_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic [Y_W-1:0] y0;
    logic           err;
  } lane_q_t;

endpackage

// ===== rtl/tpsc_lane.sv =====
`timescale 1ns / 1ps
// One interpolation lane: difference, multiply, pipelined restoring divide and saturation.
module tpsc_lane
  import tpsc_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [RAW_W-1:0] raw,
  input  logic signed [RAW_W-1:0] raw_low,
  input  logic signed [RAW_W-1:0] raw_high,
  input  logic [Y_W-1:0]          y_low,
  input  logic [Y_W-1:0]          y_high,
  output logic signed [RAW_W-1:0] res,
  output logic                    err
);

  lane_s1_t  s1_r, s1_nxt;
  lane_s2_t  s2_r, s2_nxt;
  lane_div_t div_r [0:DIV_STAGES];
  lane_div_t div_nxt [0:DIV_STAGES];
  lane_q_t   q_r, q_nxt;
  logic signed [RAW_W-1:0] res_r, res_nxt;
  logic                    err_r, err_nxt;

  always_comb begin
    s1_nxt.dr  = $signed({raw[RAW_W-1], raw}) - $signed({raw_low[RAW_W-1], raw_low});
    s1_nxt.dy  = $signed({1'b0, y_high}) - $signed({1'b0, y_low});
    s1_nxt.den = $signed({raw_high[RAW_W-1], raw_high}) - $signed({raw_low[RAW_W-1], raw_low});
    s1_nxt.y0  = y_low;
    s1_nxt.err = (raw_high == raw_low);
  end

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    logic signed [DIF_W-1:0]  den_abs;
    prod = PROD_W'($signed(s1_r.dr)) * PROD_W'($signed(s1_r.dy));
    den_abs = s1_r.den[DIF_W-1] ? -$signed(s1_r.den) : $signed(s1_r.den);
    s2_nxt.prod    = prod;
    s2_nxt.den_mag = den_abs[DEN_W-1:0];
    s2_nxt.den_neg = s1_r.den[DIF_W-1];
    s2_nxt.y0      = s1_r.y0;
    s2_nxt.err     = s1_r.err;
  end

  always_comb begin
    logic signed [PROD_W-1:0] prod_abs;
    logic                     prod_neg;
    lane_div_t                cur;
    logic [DEN_W:0]           trial;
    logic                     qbit;
    prod_neg = s2_r.prod[PROD_W-1];
    prod_abs = prod_neg ? -$signed(s2_r.prod) : $signed(s2_r.prod);
    div_nxt[0].rem = '0;
    div_nxt[0].acc = {{(QMAG_W - PROD_W){1'b0}}, prod_abs};
    div_nxt[0].den = s2_r.den_mag;
    div_nxt[0].neg = prod_neg ^ s2_r.den_neg;
    div_nxt[0].y0  = s2_r.y0;
    div_nxt[0].err = s2_r.err;
    for (int k = 0; k < DIV_STAGES; k++) begin
      cur = div_r[k];
      for (int j = 0; j < DIV_STEP; j++) begin
        trial = {cur.rem, cur.acc[QMAG_W-1]};
        qbit  = (trial >= {1'b0, cur.den});
        if (qbit) begin
          cur.rem = DEN_W'(trial - {1'b0, cur.den});
        end else begin
          cur.rem = trial[DEN_W-1:0];
        end
        cur.acc = {cur.acc[QMAG_W-2:0], qbit};
      end
      div_nxt[k+1] = cur;
    end
  end

  always_comb begin
    logic signed [Q_W-1:0] qmag;
    qmag = $signed({1'b0, div_r[DIV_STAGES].acc});
    q_nxt.q   = div_r[DIV_STAGES].neg ? -qmag : qmag;
    q_nxt.y0  = div_r[DIV_STAGES].y0;
    q_nxt.err = div_r[DIV_STAGES].err;
  end

  always_comb begin
    logic signed [SUM_W-1:0] sum;
    sum = $signed({{(SUM_W - Y_W){1'b0}}, q_r.y0}) + $signed({q_r.q[Q_W-1], q_r.q});
    priority if (q_r.err) begin
      res_nxt = '0;
    end else if (sum > SAT_MAX) begin
      res_nxt = SAT_MAX[RAW_W-1:0];
    end else if (sum < SAT_MIN) begin
      res_nxt = SAT_MIN[RAW_W-1:0];
    end else begin
      res_nxt = sum[RAW_W-1:0];
    end
    err_nxt = q_r.err;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      for (int k = 0; k <= DIV_STAGES; k++) begin
        div_r[k] <= div_nxt[k];
      end
      q_r   <= q_nxt;
      res_r <= res_nxt;
      err_r <= err_nxt;
    end
  end

  assign res = res_r;
  assign err = err_r;

endmodule

// ===== rtl/two_point_sensor_calibration.sv =====
`timescale 1ns / 1ps
// Top level of the two-point sensor calibration block with its register file and handshake.
// The block takes one raw humidity and temperature pair per clock and returns both values in
// 1/64 units through its pipeline registers: a difference stage, a multiply stage, a sign stage,
// eight restoring-divide stages of four quotient bits each, and two stages that restore the sign,
// add the low calibration point and saturate. Both lanes share one stall, so the whole pipeline
// holds while a result waits on the output; otherwise an item enters every cycle. Calibration
// registers should only be written while no item is in flight.
module two_point_sensor_calibration
  import tpsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  logic [TEMP_PT_W-1:0] temp_low_r, temp_high_r;
  logic [RAW_W-1:0]     temp_low_raw_r, temp_high_raw_r;
  logic [HUM_PT_W-1:0]  hum_low_r, hum_high_r;
  logic [RAW_W-1:0]     hum_low_raw_r, hum_high_raw_r;
  logic [LANE_LAT-1:0]  vld_r, vld_nxt;
  logic                 en;
  logic                 cfg_wr;
  logic [IDX_W-1:0]     cfg_idx;
  logic signed [RAW_W-1:0] t_res, h_res;
  logic                 t_err, h_err;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = cfg_paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_low_r      <= '0;
      temp_high_r     <= '0;
      temp_low_raw_r  <= '0;
      temp_high_raw_r <= '0;
      hum_low_r       <= '0;
      hum_high_r      <= '0;
      hum_low_raw_r   <= '0;
      hum_high_raw_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TEMP_LOW_EIGHTHS:  temp_low_r      <= cfg_pwdata[TEMP_PT_W-1:0];
        REG_TEMP_HIGH_EIGHTHS: temp_high_r     <= cfg_pwdata[TEMP_PT_W-1:0];
        REG_TEMP_LOW_RAW:      temp_low_raw_r  <= cfg_pwdata[RAW_W-1:0];
        REG_TEMP_HIGH_RAW:     temp_high_raw_r <= cfg_pwdata[RAW_W-1:0];
        REG_HUM_LOW_HALVES:    hum_low_r       <= cfg_pwdata[HUM_PT_W-1:0];
        REG_HUM_HIGH_HALVES:   hum_high_r      <= cfg_pwdata[HUM_PT_W-1:0];
        REG_HUM_LOW_RAW:       hum_low_raw_r   <= cfg_pwdata[RAW_W-1:0];
        REG_HUM_HIGH_RAW:      hum_high_raw_r  <= cfg_pwdata[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TEMP_LOW_EIGHTHS:  cfg_prdata = DATA_W'(temp_low_r);
      REG_TEMP_HIGH_EIGHTHS: cfg_prdata = DATA_W'(temp_high_r);
      REG_TEMP_LOW_RAW:      cfg_prdata = DATA_W'(temp_low_raw_r);
      REG_TEMP_HIGH_RAW:     cfg_prdata = DATA_W'(temp_high_raw_r);
      REG_HUM_LOW_HALVES:    cfg_prdata = DATA_W'(hum_low_r);
      REG_HUM_HIGH_HALVES:   cfg_prdata = DATA_W'(hum_high_r);
      REG_HUM_LOW_RAW:       cfg_prdata = DATA_W'(hum_low_raw_r);
      REG_HUM_HIGH_RAW:      cfg_prdata = DATA_W'(hum_high_raw_r);
      default:               cfg_prdata = '0;
    endcase
  end

  assign out_valid = vld_r[LANE_LAT-1];
  assign in_stall  = out_valid & out_stall;
  assign en        = ~in_stall;
  assign vld_nxt   = {vld_r[LANE_LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  tpsc_lane u_temp_lane (
    .clk      (clk),
    .en       (en),
    .raw      (in_data.temperature_raw),
    .raw_low  ($signed(temp_low_raw_r)),
    .raw_high ($signed(temp_high_raw_r)),
    .y_low    ({temp_low_r, {(Y_W - TEMP_PT_W){1'b0}}}),
    .y_high   ({temp_high_r, {(Y_W - TEMP_PT_W){1'b0}}}),
    .res      (t_res),
    .err      (t_err)
  );

  tpsc_lane u_hum_lane (
    .clk      (clk),
    .en       (en),
    .raw      (in_data.humidity_raw),
    .raw_low  ($signed(hum_low_raw_r)),
    .raw_high ($signed(hum_high_raw_r)),
    .y_low    ({hum_low_r, {(Y_W - HUM_PT_W){1'b0}}}),
    .y_high   ({hum_high_r, {(Y_W - HUM_PT_W){1'b0}}}),
    .res      (h_res),
    .err      (h_err)
  );

  always_comb begin
    out_data.temperature_q  = t_res;
    out_data.humidity_q     = h_res;
    out_data.temp_cal_error = t_err;
    out_data.hum_cal_error  = h_err;
  end

endmodule

// ===== rtl/tpsc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the two-point sensor calibration block, bound to the top level.
module tpsc_checker
  import tpsc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result item changed while stalled");

  a_take_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while the output holds no item");

  a_temp_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.temp_cal_error) |-> (out_data.temperature_q == '0))
    else $error("temperature not forced to zero on calibration error");

  a_hum_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.hum_cal_error) |-> (out_data.humidity_q == '0))
    else $error("humidity not forced to zero on calibration error");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result item present straight after reset");

endmodule

bind two_point_sensor_calibration tpsc_checker u_tpsc_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the two-point sensor calibration block: directed table, then random items.
module testbench;
  import tpsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;
  localparam int SEGMENTS    = 6;
  localparam int SEG_ITEMS   = 103;

  typedef enum {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;
  typedef enum {CAL_KEEP, CAL_NOMINAL, CAL_FULL_SPAN, CAL_STEEP, CAL_REVERSED,
                CAL_WIDE_WRITE} cal_sel_t;

  typedef struct packed {
    logic [TEMP_PT_W-1:0]    t_lo_pt;
    logic [TEMP_PT_W-1:0]    t_hi_pt;
    logic signed [RAW_W-1:0] t_lo_raw;
    logic signed [RAW_W-1:0] t_hi_raw;
    logic [HUM_PT_W-1:0]     h_lo_pt;
    logic [HUM_PT_W-1:0]     h_hi_pt;
    logic signed [RAW_W-1:0] h_lo_raw;
    logic signed [RAW_W-1:0] h_hi_raw;
  } calib_t;

  typedef struct {
    cal_sel_t  cal;
    in_item_t  stim;
    bit        known;
    out_item_t result;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0]  cfg_pwdata = '0;
  logic [DATA_W-1:0]  cfg_prdata;
  logic               cfg_pready;

  calib_t      cal_now = '0;
  logic [31:0] pending_cal [8];
  out_item_t   expected_readings [$];
  row_t        directed_rows [$];
  pace_t       pace = PACE_SLOW_SINK;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          errors = 0;
  int          cycles = 0;

  two_point_sensor_calibration u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #1 clk = ~clk;

  function automatic int src_gap_pct(input pace_t p);
    case (p)
      PACE_SLOW_SINK:   return 30;
      PACE_SLOW_SOURCE: return 62;
      default:          return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct(input pace_t p);
    case (p)
      PACE_SLOW_SINK:   return 62;
      PACE_SLOW_SOURCE: return 30;
      default:          return 0;
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] interpolate(input longint raw, input longint raw0,
                                                   input longint raw1, input longint y0,
                                                   input longint y1, output logic err);
    longint span;
    longint sum;
    span = raw1 - raw0;
    err  = (span == 0);
    if (err) return '0;
    sum = y0 + ((raw - raw0) * (y1 - y0)) / span;
    if (sum > 32767) sum = 32767;
    else if (sum < -32768) sum = -32768;
    return sum[RAW_W-1:0];
  endfunction

  function automatic out_item_t calibrate_sample(input in_item_t s);
    out_item_t r;
    logic      e;
    r.temperature_q = interpolate(s.temperature_raw, cal_now.t_lo_raw, cal_now.t_hi_raw,
                                  longint'(cal_now.t_lo_pt) * 8,
                                  longint'(cal_now.t_hi_pt) * 8, e);
    r.temp_cal_error = e;
    r.humidity_q = interpolate(s.humidity_raw, cal_now.h_lo_raw, cal_now.h_hi_raw,
                               longint'(cal_now.h_lo_pt) * 32,
                               longint'(cal_now.h_hi_pt) * 32, e);
    r.hum_cal_error = e;
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw(input int lo, input int hi);
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = $urandom();
      5, 6: v = ($urandom_range(1) ? lo : hi) + int'($urandom_range(16)) - 8;
      7: begin
        case ($urandom_range(3))
          0:       v = -32768;
          1:       v = 32767;
          2:       v = 0;
          default: v = -1;
        endcase
      end
      default: begin
        if (lo < hi) v = lo + int'($urandom_range(hi - lo));
        else v = hi + int'($urandom_range(lo - hi));
      end
    endcase
    return v[RAW_W-1:0];
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic send_item(input in_item_t s, input out_item_t want);
    while ($urandom_range(99) < src_gap_pct(pace)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_readings.push_back(want);
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (LANE_LAT) @(posedge clk);
  endtask

  task automatic write_cal_reg(input logic [IDX_W-1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_TEMP_LOW_EIGHTHS:  cal_now.t_lo_pt  = val[TEMP_PT_W-1:0];
      REG_TEMP_HIGH_EIGHTHS: cal_now.t_hi_pt  = val[TEMP_PT_W-1:0];
      REG_TEMP_LOW_RAW:      cal_now.t_lo_raw = val[RAW_W-1:0];
      REG_TEMP_HIGH_RAW:     cal_now.t_hi_raw = val[RAW_W-1:0];
      REG_HUM_LOW_HALVES:    cal_now.h_lo_pt  = val[HUM_PT_W-1:0];
      REG_HUM_HIGH_HALVES:   cal_now.h_hi_pt  = val[HUM_PT_W-1:0];
      REG_HUM_LOW_RAW:       cal_now.h_lo_raw = val[RAW_W-1:0];
      REG_HUM_HIGH_RAW:      cal_now.h_hi_raw = val[RAW_W-1:0];
      default: ;
    endcase
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_calibration();
    for (int i = 0; i < 8; i++) write_cal_reg(IDX_W'(i), pending_cal[i]);
  endtask

  task automatic set_pending(input int tlo, input int thi, input int trl, input int trh,
                             input int hlo, input int hhi, input int hrl, input int hrh);
    pending_cal[REG_TEMP_LOW_EIGHTHS]  = tlo;
    pending_cal[REG_TEMP_HIGH_EIGHTHS] = thi;
    pending_cal[REG_TEMP_LOW_RAW]      = trl;
    pending_cal[REG_TEMP_HIGH_RAW]     = trh;
    pending_cal[REG_HUM_LOW_HALVES]    = hlo;
    pending_cal[REG_HUM_HIGH_HALVES]   = hhi;
    pending_cal[REG_HUM_LOW_RAW]       = hrl;
    pending_cal[REG_HUM_HIGH_RAW]      = hrh;
  endtask

  task automatic select_calibration(input cal_sel_t c);
    case (c)
      CAL_NOMINAL:    set_pending(200, 400, -1000, 3000, 40, 160, -5000, 10000);
      CAL_FULL_SPAN:  set_pending(0, 1023, -32768, 32767, 0, 255, -32768, 32767);
      CAL_STEEP:      set_pending(0, 1023, 0, 1, 255, 0, 0, 1);
      CAL_REVERSED:   set_pending(1023, 0, 32767, -32768, 255, 0, 100, -100);
      CAL_WIDE_WRITE: set_pending(32'hFFFF_FC64, 32'h5A5A_5F20, 32'hFFFF_8000, 32'h0001_7FFF,
                                  32'hFFFF_FF10, 32'h1234_56C8, 32'hABCD_1234,
                                  32'h5555_1234);
      default: ;
    endcase
  endtask

  task automatic randomize_calibration();
    int tlo, thi, trl, trh, hlo, hhi, hrl, hrh;
    tlo = $urandom_range(1023);
    thi = $urandom_range(1023);
    hlo = $urandom_range(255);
    hhi = $urandom_range(255);
    trl = -int'($urandom_range(20000));
    trh = 1 + int'($urandom_range(30000));
    hrl = -int'($urandom_range(20000));
    hrh = 1 + int'($urandom_range(30000));
    case ($urandom_range(9))
      5: begin
        tlo = $urandom(); thi = $urandom(); trl = $urandom(); trh = $urandom();
        hlo = $urandom(); hhi = $urandom(); hrl = $urandom(); hrh = $urandom();
      end
      6: trh = trl;
      7: hrh = hrl;
      8: begin
        tlo = $urandom_range(1) ? 1023 : 0;
        thi = $urandom_range(1) ? 1023 : 0;
        hlo = $urandom_range(1) ? 255 : 0;
        hhi = $urandom_range(1) ? 255 : 0;
        trl = $urandom_range(1) ? 32767 : -32768;
        trh = $urandom_range(1) ? 32767 : -32768;
        hrl = $urandom_range(1) ? 32767 : -32768;
        hrh = $urandom_range(1) ? 32767 : -32768;
      end
      9: begin
        trh = trl + int'($urandom_range(1, 4)) * ($urandom_range(1) ? 1 : -1);
        hrh = hrl + int'($urandom_range(1, 4)) * ($urandom_range(1) ? 1 : -1);
      end
      default: ;
    endcase
    set_pending(tlo, thi, trl, trh, hlo, hhi, hrl, hrh);
  endtask

  task automatic add_row(input cal_sel_t c, input int hum, input int temp, input bit known,
                         input int tq, input int hq, input bit te, input bit he);
    row_t r;
    r.cal                    = c;
    r.stim.humidity_raw      = 16'(hum);
    r.stim.temperature_raw   = 16'(temp);
    r.known                  = known;
    r.result.temperature_q   = 16'(tq);
    r.result.humidity_q      = 16'(hq);
    r.result.temp_cal_error  = te;
    r.result.hum_cal_error   = he;
    directed_rows.push_back(r);
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct(pace));
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        $error("result item with nothing expected: %h", out_data);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        check_field("temperature_q", want.temperature_q, out_data.temperature_q);
        check_field("humidity_q", want.humidity_q, out_data.humidity_q);
        check_field("temp_cal_error", want.temp_cal_error, out_data.temp_cal_error);
        check_field("hum_cal_error", want.hum_cal_error, out_data.hum_cal_error);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** two_point_sensor_calibration: FAILED **");
      $finish;
    end
  end

  initial begin
    in_item_t s;
    add_row(CAL_KEEP, 0, 0, 1, 0, 0, 1, 1);
    add_row(CAL_KEEP, -32768, 32767, 1, 0, 0, 1, 1);
    add_row(CAL_NOMINAL, -5000, -1000, 1, 1600, 1280, 0, 0);
    add_row(CAL_KEEP, 10000, 3000, 1, 3200, 5120, 0, 0);
    add_row(CAL_KEEP, 2500, 1000, 1, 2400, 3200, 0, 0);
    add_row(CAL_KEEP, 32767, 32767, 0, 0, 0, 0, 0);
    add_row(CAL_KEEP, -32768, -32768, 0, 0, 0, 0, 0);
    add_row(CAL_KEEP, -7, 12345, 0, 0, 0, 0, 0);
    add_row(CAL_KEEP, -5001, -1001, 0, 0, 0, 0, 0);
    add_row(CAL_FULL_SPAN, -32768, -32768, 1, 0, 0, 0, 0);
    add_row(CAL_KEEP, 32767, 32767, 1, 8184, 8160, 0, 0);
    add_row(CAL_KEEP, 0, 0, 0, 0, 0, 0, 0);
    add_row(CAL_KEEP, 21845, -1, 0, 0, 0, 0, 0);
    add_row(CAL_STEEP, 32767, 32767, 1, 32767, -32768, 0, 0);
    add_row(CAL_KEEP, -32768, -32768, 1, -32768, 32767, 0, 0);
    add_row(CAL_KEEP, 0, 0, 1, 0, 8160, 0, 0);
    add_row(CAL_KEEP, 1, 1, 1, 8184, 0, 0, 0);
    add_row(CAL_KEEP, 4, 4, 0, 0, 0, 0, 0);
    add_row(CAL_REVERSED, 100, 32767, 1, 8184, 8160, 0, 0);
    add_row(CAL_KEEP, -100, -32768, 1, 0, 0, 0, 0);
    add_row(CAL_KEEP, 0, 0, 0, 0, 0, 0, 0);
    add_row(CAL_KEEP, 300, 5, 0, 0, 0, 0, 0);
    add_row(CAL_WIDE_WRITE, 0, -32768, 1, 800, 0, 0, 1);
    add_row(CAL_KEEP, -32768, 32767, 1, 6400, 0, 0, 1);
    add_row(CAL_KEEP, 16'h1234, 777, 0, 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cal != CAL_KEEP) begin
        drain_pipeline();
        select_calibration(directed_rows[i].cal);
        program_calibration();
      end
      send_item(directed_rows[i].stim, directed_rows[i].known ? directed_rows[i].result
                                                              : calibrate_sample(
                                                                  directed_rows[i].stim));
    end

    for (int p = 0; p < 3; p++) begin
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        drain_pipeline();
        pace = pace_t'(p);
        randomize_calibration();
        program_calibration();
        if (pace == PACE_FULL && seg == 1) hold_req = 1'b1;
        for (int n = 0; n < SEG_ITEMS; n++) begin
          s.temperature_raw = pick_raw(cal_now.t_lo_raw, cal_now.t_hi_raw);
          s.humidity_raw    = pick_raw(cal_now.h_lo_raw, cal_now.h_hi_raw);
          send_item(s, calibrate_sample(s));
        end
      end
    end

    drain_pipeline();
    if (errors == 0) begin
      $display("** two_point_sensor_calibration: PASSED **");
    end else begin
      $display("** two_point_sensor_calibration: FAILED **");
    end
    $finish;
  end

endmodule

// ===== two_point_sensor_calibration.f =====
rtl/tpsc_pkg.sv
rtl/tpsc_lane.sv
rtl/two_point_sensor_calibration.sv
rtl/tpsc_checker.sv
tb/testbench.sv
